@@ rtl/core/shaeng_pkg.sv @@
// Types, constants and round functions shared by the SHA-256 engine.
`timescale 1ns / 1ps
package shaeng_pkg;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUSH2, ST_PADCHK, ST_ZERO, ST_LOAD, ST_RUN, ST_ADD, ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } item_t;

  localparam logic [31:0] PadWord = 32'h8000_0000;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] iv_word(input logic v, input logic [2:0] i);
    logic [31:0] r;
    case ({v, i})
      4'd0:    r = 32'h6a09e667;
      4'd1:    r = 32'hbb67ae85;
      4'd2:    r = 32'h3c6ef372;
      4'd3:    r = 32'ha54ff53a;
      4'd4:    r = 32'h510e527f;
      4'd5:    r = 32'h9b05688c;
      4'd6:    r = 32'h1f83d9ab;
      4'd7:    r = 32'h5be0cd19;
      4'd8:    r = 32'hc1059ed8;
      4'd9:    r = 32'h367cd507;
      4'd10:   r = 32'h3070dd17;
      4'd11:   r = 32'hf70e5939;
      4'd12:   r = 32'hffc00b31;
      4'd13:   r = 32'h68581511;
      4'd14:   r = 32'h64f98fa7;
      default: r = 32'hbefa4fa4;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ rtl/core/shaeng_front.sv @@
// Input side: classifies incoming words and holds them in a two-entry queue.
`timescale 1ns / 1ps
module shaeng_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [31:0]         data_word_i,
  input  logic [2:0]          byte_count_i,
  input  logic                last_word_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                take_i,
  output shaeng_pkg::item_t   item_o
);

  shaeng_pkg::item_t mem_q [2];
  shaeng_pkg::item_t cls;
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        wr_en, rd_en;
  logic [2:0]  cnt;

  // A byte count is saturated to four bytes; a last word of under four bytes carries its padding byte.
  always_comb begin
    cnt = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    cls.count = cnt;
    cls.last  = last_word_i;
    cls.word  = data_word_i;
    if (last_word_i) begin
      case (cnt)
        3'd0:    cls.word = 32'h8000_0000;
        3'd1:    cls.word = {data_word_i[31:24], 24'h80_0000};
        3'd2:    cls.word = {data_word_i[31:16], 16'h8000};
        3'd3:    cls.word = {data_word_i[31:8], 8'h80};
        default: cls.word = data_word_i;
      endcase
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_q <= !wr_q;
      end
      if (rd_en) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

@@ rtl/core/shaeng_back.sv @@
// Back end: block buffer, padding sequencer, round datapath and digest output.
`timescale 1ns / 1ps
module shaeng_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  shaeng_pkg::item_t   item_i,
  output logic                take_o,
  input  logic                variant_i,
  input  logic                cfg_we_i,
  input  logic                cfg_variant_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_digest_o
);

  shaeng_pkg::state_e state_q, state_d, after_q, after_d;
  logic [31:0] buf_q  [16];
  logic [31:0] hash_q [8];
  logic [31:0] v_q    [8];
  logic [3:0]  wf_q;
  logic [63:0] bits_q, total_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        push_en, len_en, restart;
  logic [31:0] push_word, w_new, t1, t2;
  logic [2:0]  last_idx;

  assign last_idx = variant_i ? 3'd6 : 3'd7;

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    case (state_q)
      shaeng_pkg::ST_IDLE: begin
        if (valid_i) begin
          if (!item_i.last) begin
            after_d = shaeng_pkg::ST_IDLE;
          end else if (item_i.count == 3'd4) begin
            after_d = shaeng_pkg::ST_PUSH2;
          end else begin
            after_d = shaeng_pkg::ST_PADCHK;
          end
          state_d = (wf_q == 4'hf) ? shaeng_pkg::ST_LOAD : after_d;
        end
      end
      shaeng_pkg::ST_PUSH2: begin
        after_d = shaeng_pkg::ST_PADCHK;
        state_d = (wf_q == 4'hf) ? shaeng_pkg::ST_LOAD : shaeng_pkg::ST_PADCHK;
      end
      shaeng_pkg::ST_PADCHK: begin
        after_d = shaeng_pkg::ST_ZERO;
        state_d = (wf_q == 4'hf) ? shaeng_pkg::ST_LOAD : shaeng_pkg::ST_ZERO;
      end
      shaeng_pkg::ST_ZERO: begin
        if (wf_q == 4'd14) begin
          after_d = shaeng_pkg::ST_OUT;
          state_d = shaeng_pkg::ST_LOAD;
        end
      end
      shaeng_pkg::ST_LOAD: state_d = shaeng_pkg::ST_RUN;
      shaeng_pkg::ST_RUN: begin
        if (rnd_q == 6'd63) begin
          state_d = shaeng_pkg::ST_ADD;
        end
      end
      shaeng_pkg::ST_ADD: state_d = after_q;
      shaeng_pkg::ST_OUT: begin
        if (pop_i && idx_q == last_idx) begin
          state_d = shaeng_pkg::ST_IDLE;
        end
      end
      default: state_d = shaeng_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take_o    = 1'b0;
    push_en   = 1'b0;
    len_en    = 1'b0;
    push_word = item_i.word;
    empty_o   = 1'b1;
    case (state_q)
      shaeng_pkg::ST_IDLE: begin
        take_o  = valid_i;
        push_en = valid_i;
      end
      shaeng_pkg::ST_PUSH2: begin
        push_en   = 1'b1;
        push_word = shaeng_pkg::PadWord;
      end
      shaeng_pkg::ST_PADCHK: begin
        push_en   = (wf_q == 4'hf);
        push_word = '0;
      end
      shaeng_pkg::ST_ZERO: begin
        push_en   = (wf_q != 4'd14);
        len_en    = (wf_q == 4'd14);
        push_word = '0;
      end
      shaeng_pkg::ST_OUT: empty_o = 1'b0;
      default: ;
    endcase
  end

  assign restart = (state_q == shaeng_pkg::ST_OUT) && pop_i && (idx_q == last_idx);

  assign w_new = shaeng_pkg::small_s1(buf_q[14]) + buf_q[9]
               + shaeng_pkg::small_s0(buf_q[1]) + buf_q[0];
  assign t1 = v_q[7] + shaeng_pkg::big_s1(v_q[4])
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + shaeng_pkg::RoundK[rnd_q] + buf_q[0];
  assign t2 = shaeng_pkg::big_s0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      buf_q[wf_q] <= push_word;
    end else if (len_en) begin
      buf_q[14] <= total_q[63:32];
      buf_q[15] <= total_q[31:0];
    end else if (state_q == shaeng_pkg::ST_RUN) begin
      for (int i = 0; i < 15; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
      buf_q[15] <= w_new;
    end
    if (take_o && item_i.last) begin
      total_q <= bits_q + {58'd0, item_i.count, 3'd0};
    end
    if (state_q == shaeng_pkg::ST_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= hash_q[i];
      end
    end else if (state_q == shaeng_pkg::ST_RUN) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shaeng_pkg::ST_IDLE;
      after_q <= shaeng_pkg::ST_IDLE;
      wf_q    <= 4'd0;
      bits_q  <= 64'd0;
      rnd_q   <= 6'd0;
      idx_q   <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= shaeng_pkg::iv_word(1'b0, 3'(i));
      end
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      if (push_en) begin
        wf_q <= wf_q + 4'd1;
      end else if (len_en) begin
        wf_q <= 4'd0;
      end
      if (take_o && !item_i.last) begin
        bits_q <= bits_q + 64'd32;
      end
      rnd_q <= (state_q == shaeng_pkg::ST_RUN) ? rnd_q + 6'd1 : 6'd0;
      if (state_q == shaeng_pkg::ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + v_q[i];
        end
      end
      if (state_q == shaeng_pkg::ST_OUT && pop_i) begin
        idx_q <= restart ? 3'd0 : idx_q + 3'd1;
      end
      if (restart || cfg_we_i) begin
        wf_q   <= 4'd0;
        bits_q <= 64'd0;
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= shaeng_pkg::iv_word(cfg_we_i ? cfg_variant_i : variant_i, 3'(i));
        end
      end
    end
  end

  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_digest_o = (idx_q == last_idx);

endmodule

@@ rtl/core/sha256_hash_engine.sv @@
// Top level of the SHA-256/SHA-224 engine with its register port.
`timescale 1ns / 1ps
// Message words enter through a queue-style port: a request is taken when
// push is high and full is low. Each word carries up to four bytes, the first
// in the top byte; the word marked last closes the message and holds 0 to 4
// valid bytes. Digest words leave through a second queue-style port: the
// oldest word is shown while empty is low and is taken when pop is high.
// A two-entry input queue lets words arrive while the back end is busy.
// A non-last word is stored in the block buffer, and the sixteenth word of
// a block starts a compression (load, 64 rounds, add) on the single round
// unit; while it runs the back end takes no further words from the queue.
// A last word adds up to two compressions and a zero fill up to the length
// words, after which seven or eight digest words follow, one per pop.
// While the receiver stalls the digest words wait and the back end holds;
// the input queue still takes up to two words. Reset selects SHA-256 and
// loads its initial hash. Writing the variant register restarts the message.
module sha256_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_digest_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  shaeng_pkg::item_t item;
  logic item_valid, take, cfg_we, variant_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == 2'd0);
  assign prdata = {31'd0, variant_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
    end else if (cfg_we) begin
      variant_q <= pwdata[0];
    end
  end

  shaeng_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .full_o       (full),
    .valid_o      (item_valid),
    .take_i       (take),
    .item_o       (item)
  );

  shaeng_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (item_valid),
    .item_i        (item),
    .take_o        (take),
    .variant_i     (variant_q),
    .cfg_we_i      (cfg_we),
    .cfg_variant_i (pwdata[0]),
    .empty_o       (empty),
    .pop_i         (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_digest_o (last_digest_o)
  );

`ifndef SYNTH
  a_last_pop_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_digest_o) |=> empty)
    else $error("digest output stayed busy after its final word");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_digest_o) |=>
      (!empty && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word index did not advance");

  a_first_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && $past(empty)) |-> (word_index_o == 3'd0))
    else $error("digest did not start at word zero");
`endif

endmodule

@@ bench/sha256_digest_checker.sv @@
// Digest predictor and checker that watches the SHA-256 engine's ports.
`timescale 1ns / 1ps
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_digest_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          digests_pending_o
);

  localparam logic [1:0] VariantAddr = 2'd0;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  logic        sha224_mode;
  logic [31:0] chain [8];
  logic [31:0] blk_words [16];
  logic [3:0]  fill;
  logic [63:0] bit_len;
  digest_t     digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] initial_hash(input logic sel, input int i);
    logic [31:0] h256 [8];
    logic [31:0] h224 [8];
    h256 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    h224 = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
             32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
    return sel ? h224[i] : h256[i];
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = initial_hash(sha224_mode, i);
    fill = '0;
    bit_len = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int j = 0; j < 16; j++) w[j] = blk_words[j];
    for (int j = 16; j < 64; j++) begin
      s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = s1 + w[j-7] + s0 + w[j-16];
    end
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int j = 0; j < 64; j++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shaeng_pkg::RoundK[j] + w[j];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
  endtask

  task automatic store_word(input logic [31:0] w);
    blk_words[fill] = w;
    fill = fill + 4'd1;
    if (fill == 4'd0) compress_block();
  endtask

  task automatic absorb_request(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    logic [2:0]  n;
    logic [63:0] total;
    logic [31:0] mask;
    int          nwords;
    digest_t     d;
    if (!lst) begin
      bit_len += 64'd32;
      store_word(w);
    end else begin
      n = (cnt > 3'd4) ? 3'd4 : cnt;
      total = bit_len + 64'(8 * n);
      mask = (n == 3'd0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      if (n < 3'd4) begin
        store_word((w & mask) | (32'h80 << (24 - 8 * n)));
      end else begin
        store_word(w);
        store_word(shaeng_pkg::PadWord);
      end
      if (fill > 4'd14) begin
        for (int i = fill; i < 16; i++) blk_words[i] = '0;
        compress_block();
        fill = '0;
      end
      for (int i = fill; i < 14; i++) blk_words[i] = '0;
      blk_words[14] = total[63:32];
      blk_words[15] = total[31:0];
      compress_block();
      nwords = sha224_mode ? 7 : 8;
      for (int i = 0; i < nwords; i++) begin
        d.word = chain[i];
        d.index = 3'(i);
        d.last = (i + 1 == nwords);
        digest_q.push_back(d);
      end
      restart_message();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_t d;
    if (!rst_ni) begin
      sha224_mode = 1'b0;
      restart_message();
      digest_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == VariantAddr) begin
        sha224_mode = pwdata_i[0];
        restart_message();
      end
      if (push_i && !full_i) absorb_request(data_word_i, byte_count_i, last_word_i);
      if (pop_i && !empty_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest word %h with nothing expected", $time, digest_word_i);
          fail_count_o++;
        end else begin
          d = digest_q.pop_front();
          if (d.word !== digest_word_i || d.index !== word_index_i
              || d.last !== last_digest_i) begin
            $display("%0t: expected word %h index %0d last %b, got %h index %0d last %b",
                     $time, d.word, d.index, d.last,
                     digest_word_i, word_index_i, last_digest_i);
            fail_count_o++;
          end
        end
      end
    end
    digests_pending_o = digest_q.size();
  end

endmodule

@@ bench/tb_sha256_hash_engine.sv @@
// Top of the SHA-256 engine testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module tb_sha256_hash_engine;

  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] data_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        last_word_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_digest_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          digests_pending;
  int          cycle_count = 0;
  int          words_sent = 0;

  sha256_hash_engine dut (.*);

  sha256_digest_checker checker_i (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .data_word_i, .byte_count_i,
    .last_word_i, .empty_i(empty), .pop_i(pop), .digest_word_i(digest_word_o),
    .word_index_i(word_index_o), .last_digest_i(last_digest_o), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .digests_pending_o(digests_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver holds off for a long stretch once, so the engine fills up.
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      while (cycle_count > 3000 && cycle_count < 3800) begin
        pop <= 1'b0;
        @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    int gap;
    gap = $urandom_range(0, 4);
    if (words_sent % 40 < 10) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    data_word_i <= w;
    byte_count_i <= cnt;
    last_word_i <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_message(input int nwords, input logic [2:0] cnt);
    for (int i = 0; i < nwords; i++) send_word($urandom, 3'($urandom), 1'b0);
    send_word($urandom, cnt, 1'b1);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (digests_pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_variant(input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'd0;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_variant(32'hffff_fffe);
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'h6162_6300, 3'd5, 1'b1);
    send_word(32'hffff_ffff, 3'd6, 1'b1);
    send_word(32'ha5a5_5a5a, 3'd7, 1'b1);
    for (int i = 0; i < 14; i++) send_word(i[0] ? 32'hffff_ffff : 32'h0, 3'd7, 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    drain();
    write_variant(32'h0000_0001);
    for (int m = 0; m < 3; m++) begin
      while (words_sent < 100 + 75 * m) begin
        if ($urandom_range(0, 9) == 0) send_message($urandom_range(30, 40), 3'($urandom));
        else send_message($urandom_range(0, 17), 3'($urandom));
      end
      drain();
      write_variant(m[0] ? 32'hffff_ffff : 32'h8000_0000);
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/shaeng_pkg.sv
rtl/core/shaeng_front.sv
rtl/core/shaeng_back.sv
rtl/core/sha256_hash_engine.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_hash_engine.sv
